// ===== rtl/bcm_pkg.sv =====
// Shared constants and types for the binary code modulation LED driver.
package bcm_pkg;

	// Number of sectors held in the color store
	localparam int SECTOR_COUNT = 32;
	// Store address width
	localparam int SECT_AW = (SECTOR_COUNT > 1) ? $clog2(SECTOR_COUNT) : 1;
	// Width that holds both the sector index field and any store address
	localparam int IDX_W = (SECT_AW > 5) ? SECT_AW : 5;

	// Field widths
	localparam int INDEX_W = 5;
	localparam int RGB_W   = 24;
	localparam int BYTE_W  = 8;

	// Input opcodes
	localparam logic OP_TICK  = 1'b0;
	localparam logic OP_WRITE = 1'b1;

	// Channel codes, in run order
	localparam logic [1:0] CH_BLUE  = 2'd0;
	localparam logic [1:0] CH_GREEN = 2'd1;
	localparam logic [1:0] CH_RED   = 2'd2;

	// Request from the run sequencer to the color store
	typedef struct packed {
		logic               we;
		logic [SECT_AW-1:0] waddr;
		logic [RGB_W-1:0]   wdata;
		logic               re;
		logic [SECT_AW-1:0] raddr;
	} ram_req_t;

endpackage

// ===== rtl/bcm_color_ram.sv =====
// Sector color store: one write and one registered read port, with per-entry valid bits.
module bcm_color_ram
	import bcm_pkg::*;
(
	input  logic             clk,
	input  logic             arst_n,
	input  ram_req_t         req,
	output logic [RGB_W-1:0] rdata
);

	logic [RGB_W-1:0]        mem [SECTOR_COUNT];
	logic [SECTOR_COUNT-1:0] valid_q;
	logic [RGB_W-1:0]        rdata_q;
	logic                    rvalid_q;

	// Storage array, no reset
	always_ff @(posedge clk) begin
		if (req.we) begin
			mem[req.waddr] <= req.wdata;
		end
		if (req.re) begin
			rdata_q <= mem[req.raddr];
		end
	end

	// Valid bits: an entry never written reads as black
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q  <= '0;
			rvalid_q <= 1'b0;
		end else begin
			if (req.we) begin
				valid_q[req.waddr] <= 1'b1;
			end
			if (req.re) begin
				rvalid_q <= valid_q[req.raddr];
			end
		end
	end

	assign rdata = rvalid_q ? rdata_q : '0;

endmodule

// ===== rtl/bcm_run_seq.sv =====
// Run sequencer: tick counter, store access, bit-plane byte assembly and output register.
module bcm_run_seq
	import bcm_pkg::*;
(
	input  logic               clk,
	input  logic               arst_n,
	// input transactions
	input  logic               s_tvalid,
	output logic               s_tready,
	input  logic               opcode,
	input  logic [INDEX_W-1:0] sector_index,
	input  logic [RGB_W-1:0]   sector_rgb,
	// color store
	output ram_req_t           req,
	input  logic [RGB_W-1:0]   rdata,
	// result transactions
	output logic               m_tvalid,
	input  logic               m_tready,
	output logic [BYTE_W-1:0]  shift_byte,
	output logic [BYTE_W-1:0]  plane_mask,
	output logic               last_byte
);

	localparam logic [1:0] ST_IDLE  = 2'd0;
	localparam logic [1:0] ST_RUN   = 2'd1;
	localparam logic [1:0] ST_DRAIN = 2'd2;

	localparam logic [SECT_AW-1:0] K_TOP = SECT_AW'(SECTOR_COUNT - 1);
	localparam logic [IDX_W:0]     K_LIM = (IDX_W + 1)'(SECTOR_COUNT);

	logic [1:0]         state_q;
	logic [BYTE_W-1:0]  tick_q;
	logic [BYTE_W-1:0]  mask_q;
	logic [SECT_AW-1:0] k_q;
	logic [1:0]         chan_q;
	logic [BYTE_W-1:0]  acc_q;

	// stage 1: read data returning from the store
	logic               valid_s1;
	logic [2:0]         k_s1;
	logic [1:0]         chan_s1;
	logic               last_s1;

	// output register
	logic               out_valid_q;
	logic [BYTE_W-1:0]  out_byte_q;
	logic [BYTE_W-1:0]  out_mask_q;
	logic               out_last_q;

	logic               in_fire;
	logic [BYTE_W-1:0]  tick_nxt;
	logic               tick_run;
	logic [IDX_W-1:0]   idx_wide;
	logic               idx_ok;
	logic               emit_s1;
	logic               out_free;
	logic               go_s1;
	logic               can_issue;
	logic               issue_last;
	logic [BYTE_W-1:0]  chan_val;
	logic               hit;

	assign s_tready = (state_q == ST_IDLE);
	assign in_fire  = s_tvalid && s_tready;

	// tick decode: zero or a power of two starts a run
	assign tick_nxt = tick_q + 8'd1;
	assign tick_run = ((tick_nxt & (tick_nxt - 8'd1)) == '0);

	// write decode: indexes past the store are dropped
	assign idx_wide = IDX_W'(sector_index);
	assign idx_ok   = ({1'b0, idx_wide} < K_LIM);

	// pipeline flow control
	assign emit_s1    = (k_s1 == 3'd0);
	assign out_free   = !out_valid_q || m_tready;
	assign go_s1      = valid_s1 && (!emit_s1 || out_free);
	assign can_issue  = (state_q == ST_RUN) && (!valid_s1 || go_s1);
	assign issue_last = (chan_q == CH_RED) && (k_q == '0);

	// store request
	always_comb begin
		req.we    = in_fire && (opcode == OP_WRITE) && idx_ok;
		req.waddr = idx_wide[SECT_AW-1:0];
		req.wdata = sector_rgb;
		req.re    = can_issue;
		req.raddr = k_q;
	end

	// channel select on returned color
	always_comb begin
		case (chan_s1)
			CH_BLUE:  chan_val = rdata[7:0];
			CH_GREEN: chan_val = rdata[15:8];
			CH_RED:   chan_val = rdata[23:16];
			default:  chan_val = '0;
		endcase
	end
	assign hit = |(chan_val & mask_q);

	// control: state, counters, stage-1 valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= ST_IDLE;
			tick_q   <= '0;
			k_q      <= '0;
			chan_q   <= CH_BLUE;
			valid_s1 <= 1'b0;
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (in_fire && (opcode == OP_TICK)) begin
						tick_q <= tick_nxt;
						if (tick_run) begin
							state_q <= ST_RUN;
							k_q     <= K_TOP;
							chan_q  <= CH_BLUE;
						end
					end
				end
				ST_RUN: begin
					if (can_issue) begin
						if (k_q == '0) begin
							k_q    <= K_TOP;
							chan_q <= chan_q + 2'd1;
						end else begin
							k_q <= k_q - SECT_AW'(1);
						end
						if (issue_last) begin
							state_q <= ST_DRAIN;
						end
					end
				end
				ST_DRAIN: begin
					if (!valid_s1) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase

			if (can_issue) begin
				valid_s1 <= 1'b1;
			end else if (go_s1) begin
				valid_s1 <= 1'b0;
			end
		end
	end

	// stage-1 tags, run mask and byte accumulator
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			acc_q <= '0;
		end else if (go_s1) begin
			if (emit_s1) begin
				acc_q <= '0;
			end else begin
				acc_q <= acc_q | (BYTE_W'(hit) << (3'd7 - k_s1));
			end
		end
	end

	always_ff @(posedge clk) begin
		if (in_fire && (opcode == OP_TICK) && tick_run) begin
			mask_q <= tick_nxt;
		end
		if (can_issue) begin
			k_s1    <= k_q[2:0];
			chan_s1 <= chan_q;
			last_s1 <= issue_last;
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (go_s1 && emit_s1) begin
			out_valid_q <= 1'b1;
		end else if (m_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (go_s1 && emit_s1) begin
			out_byte_q <= acc_q | {hit, 7'b0};
			out_mask_q <= mask_q;
			out_last_q <= last_s1;
		end
	end

	assign m_tvalid   = out_valid_q;
	assign shift_byte = out_byte_q;
	assign plane_mask = out_mask_q;
	assign last_byte  = out_last_q;

`ifndef SYNTHESIS
	// no store read outside a run
	a_no_read_idle: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_IDLE) |-> !req.re)
		else $error("store read while idle");

	// pending stage-1 data never outlives its run
	a_s1_in_run: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 |-> (state_q != ST_IDLE))
		else $error("stage 1 valid while idle");

	// writes only happen while no read is in flight
	a_rw_excl: assert property (@(posedge clk) disable iff (!arst_n)
		!(req.we && req.re))
		else $error("store write during run read");

	// a delivered byte carries a zero or power-of-two mask
	a_mask_pow2: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> ((plane_mask & (plane_mask - 8'd1)) == '0))
		else $error("plane mask not a power of two");
`endif

endmodule

// ===== rtl/bcm_rgb_shift_register_driver.sv =====
// Top level of the binary code modulation LED shift-register driver.
// Write transactions (tuser = 1) store a 24-bit color for one sector and take one cycle.
// Tick transactions (tuser = 0) advance an 8-bit wrapping counter; when the new value
// is zero or a power of two the block streams one run of 3 * ceil(SECTOR_COUNT / 8)
// bytes (blue, green, red; sectors from highest to lowest), with tlast on the final
// byte. A run reads the color store once per sector per channel, and a stalled output
// stops the store reads. Other ticks only advance the counter. New transactions are
// taken again once the last store read has been used and the sequencer is idle.
// The store resets to black through per-entry valid bits, so no clearing pass is run.
module bcm_rgb_shift_register_driver
	import bcm_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [31:0] s_tdata,  // [4:0] sector_index, [28:5] sector_rgb, [31:29] zero
	input  logic [0:0]  s_tuser,  // [0] opcode
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [15:0] m_tdata,  // [7:0] shift_byte, [15:8] plane_mask
	output logic        m_tlast   // last_byte
);

	ram_req_t          req;
	logic [RGB_W-1:0]  rdata;
	logic [BYTE_W-1:0] shift_byte;
	logic [BYTE_W-1:0] plane_mask;

	bcm_run_seq u_seq (
		.clk          (clk),
		.arst_n       (arst_n),
		.s_tvalid     (s_tvalid),
		.s_tready     (s_tready),
		.opcode       (s_tuser[0]),
		.sector_index (s_tdata[4:0]),
		.sector_rgb   (s_tdata[28:5]),
		.req          (req),
		.rdata        (rdata),
		.m_tvalid     (m_tvalid),
		.m_tready     (m_tready),
		.shift_byte   (shift_byte),
		.plane_mask   (plane_mask),
		.last_byte    (m_tlast)
	);

	bcm_color_ram u_ram (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req),
		.rdata  (rdata)
	);

	// pack result fields
	assign m_tdata = {plane_mask, shift_byte};

endmodule

// ===== tb/sv/tb_top.sv =====
// Self-checking testbench for the binary code modulation LED shift-register driver.
module tb_top;
	import bcm_pkg::*;

	// One shifted byte as seen on the master side
	typedef struct packed {
		logic [BYTE_W-1:0] shift_byte;
		logic [BYTE_W-1:0] plane_mask;
		logic              last_byte;
	} led_byte_t;

	localparam int CYCLE_LIMIT = 400000;
	localparam int RUN_CYCLES  = 3 * SECTOR_COUNT + 8;

	logic        clk;
	logic        arst_n;
	logic        s_tvalid;
	logic        s_tready;
	logic [31:0] s_tdata;  // [4:0] sector_index, [28:5] sector_rgb, [31:29] zero
	logic [0:0]  s_tuser;  // [0] opcode
	logic        m_tvalid;
	logic        m_tready = 1'b0;
	logic [15:0] m_tdata;  // [7:0] shift_byte, [15:8] plane_mask
	logic        m_tlast;  // last_byte

	// Shadow state of the block
	logic [RGB_W-1:0]  color_store [SECTOR_COUNT] = '{default: '0};
	logic [BYTE_W-1:0] tick_cnt = '0;
	led_byte_t         byte_q [$];

	int  err_cnt = 0;
	int  cycle_cnt = 0;
	bit  idle_on;
	int  stall_left = 0;

	bcm_rgb_shift_register_driver u_dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tlast  (m_tlast)
	);

	// Clock
	always begin
		clk = 1'b0;
		#2;
		clk = 1'b1;
		#2;
	end

	// Cycle limit
	always @(posedge clk) begin
		cycle_cnt <= cycle_cnt + 1;
		if (cycle_cnt > CYCLE_LIMIT) begin
			$display("Test completed with failures");
			$finish;
		end
	end

	task automatic note_error(input string msg);
		err_cnt++;
		if (err_cnt <= 10)
			$display("ERROR @%0t: %s", $realtime, msg);
	endtask

	// Update shadow state for one accepted transaction and queue the bytes it emits
	task automatic predict_led_bytes(input logic op, input logic [INDEX_W-1:0] idx,
			input logic [RGB_W-1:0] rgb);
		logic [BYTE_W-1:0] mask;
		logic [BYTE_W-1:0] acc;
		logic [BYTE_W-1:0] chan_val;
		led_byte_t         b;
		int                k;
		if (op == OP_WRITE) begin
			if (int'(idx) < SECTOR_COUNT)
				color_store[idx] = rgb;
		end else begin
			tick_cnt = tick_cnt + 8'd1;
			mask = tick_cnt;
			if ((mask & (mask - 8'd1)) == '0) begin
				acc = '0;
				for (int ch = int'(CH_BLUE); ch <= int'(CH_RED); ch++) begin
					for (k = SECTOR_COUNT - 1; k >= 0; k--) begin
						chan_val = color_store[k][ch*8 +: 8];
						if ((chan_val & mask) != '0)
							acc[7 - (k % 8)] = 1'b1;
						if (k % 8 == 0) begin
							b.shift_byte = acc;
							b.plane_mask = mask;
							b.last_byte  = (ch == int'(CH_RED)) && (k == 0);
							byte_q.push_back(b);
							acc = '0;
						end
					end
				end
			end
		end
	endtask

	// Monitor: predict on input transactions, check output transactions
	always @(posedge clk) begin : mon
		led_byte_t got;
		led_byte_t want;
		if (arst_n) begin
			if (s_tvalid && s_tready)
				predict_led_bytes(s_tuser[0], s_tdata[4:0], s_tdata[28:5]);
			if (m_tvalid && m_tready) begin
				got.shift_byte = m_tdata[7:0];
				got.plane_mask = m_tdata[15:8];
				got.last_byte  = m_tlast;
				if (byte_q.size() == 0) begin
					note_error($sformatf("unexpected byte %02h mask %02h last %0b",
						got.shift_byte, got.plane_mask, got.last_byte));
				end else begin
					want = byte_q.pop_front();
					if (got !== want)
						note_error($sformatf(
							"byte %02h/%02h mask %02h/%02h last %0b/%0b (exp/act)",
							want.shift_byte, got.shift_byte, want.plane_mask,
							got.plane_mask, want.last_byte, got.last_byte));
				end
			end
		end
	end

	// Receiver back-pressure in random bursts
	always @(posedge clk) begin
		if (stall_left > 0) begin
			stall_left <= stall_left - 1;
			m_tready <= 1'b0;
		end else if (idle_on && $urandom_range(0, 15) == 0) begin
			stall_left <= $urandom_range(1, 18) - 1;
			m_tready <= 1'b0;
		end else begin
			m_tready <= 1'b1;
		end
	end

	// Send one transaction; returns at the accepting edge
	task automatic send_item(input logic op, input logic [INDEX_W-1:0] idx,
			input logic [RGB_W-1:0] rgb);
		if (idle_on && $urandom_range(0, 3) == 0) begin
			s_tvalid <= 1'b0;
			repeat ($urandom_range(1, 18)) @(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tuser  <= op;
		s_tdata  <= {3'b000, rgb, idx};
		@(posedge clk);
		while (!s_tready)
			@(posedge clk);
	endtask

	task automatic send_tick();
		send_item(OP_TICK, INDEX_W'($urandom), RGB_W'($urandom));
	endtask

	// Hold off the sender until every queued byte has come out
	task automatic wait_for_drain();
		s_tvalid <= 1'b0;
		@(posedge clk);
		while (byte_q.size() != 0)
			@(posedge clk);
		repeat (8) @(posedge clk);
	endtask

	// First tick after reset: mask 1 over a black store
	task automatic test_black_run();
		send_tick();
		wait_for_drain();
	endtask

	// Index and color extremes, silent ticks and power-of-two ticks
	task automatic test_extremes();
		send_item(OP_WRITE, 5'd31, 24'hFFFFFF);
		send_item(OP_WRITE, 5'd0, 24'hFFFFFF);
		send_item(OP_WRITE, 5'd8, 24'h020202);
		send_item(OP_WRITE, 5'd17, 24'h800000);
		send_item(OP_WRITE, 5'd23, 24'h000000);
		send_tick();  // mask 2
		send_tick();  // 3: no output
		send_tick();  // mask 4
		send_item(OP_WRITE, 5'd31, 24'h000000);
		send_item(OP_WRITE, 5'd15, 24'h0F0F0F);
		repeat (4) send_tick();  // up to mask 8
		wait_for_drain();
	endtask

	// Random mix of color writes and ticks
	task automatic test_random_mix();
		for (int n = 0; n < 170; n++) begin
			if ($urandom_range(0, 1))
				send_item(OP_WRITE, INDEX_W'($urandom), RGB_W'($urandom));
			else
				send_tick();
			if (n == 85)
				wait_for_drain();
		end
		wait_for_drain();
	endtask

	// Run the counter through its wrap to a zero mask and on to mask 1
	task automatic test_counter_wrap();
		int n_ticks;
		send_item(OP_WRITE, 5'd0, 24'hFFFFFF);
		send_item(OP_WRITE, 5'd31, 24'hFFFFFF);
		n_ticks = 256 - int'(tick_cnt) + 1;
		for (int n = 0; n < n_ticks; n++)
			send_tick();
	endtask

	initial begin
		idle_on    = 1'b1;
		arst_n   <= 1'b0;
		s_tvalid <= 1'b0;
		s_tuser  <= OP_TICK;
		s_tdata  <= '0;
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_black_run();
		test_extremes();
		test_random_mix();
		idle_on = 1'b0;
		test_counter_wrap();

		wait_for_drain();
		repeat (RUN_CYCLES) @(posedge clk);
		if (err_cnt == 0 && byte_q.size() == 0) begin
			$display("Test completed successfully");
		end else begin
			$display("Test completed with failures");
		end
		$finish;
	end

endmodule
